FILE: rtl/signed_add_sub_mul_div_unit_macros.svh
// Assertion macros shared by the checker of the signed arithmetic unit.
// Each macro expands to one labeled concurrent assertion with reset masking.
`ifndef SIGNED_ADD_SUB_MUL_DIV_UNIT_MACROS_SVH
`define SIGNED_ADD_SUB_MUL_DIV_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASMD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/asmd_pkg.sv
// Shared types for the signed add/subtract/multiply/divide unit.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package asmd_pkg;

    // Operation codes carried in the lowest two bits of an input item.
    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG_A,
        ST_MAG_B,
        ST_ITER,
        ST_FIX,
        ST_ADDSUB
    } state_t;

    // Datapath operation issued by the sequencer each cycle.
    typedef enum logic [3:0] {
        OP_HOLD,
        OP_LOAD,
        OP_MAG_A,
        OP_MAG_B,
        OP_MUL_STEP,
        OP_DIV_STEP,
        OP_MUL_FIX,
        OP_DIV_FIX,
        OP_ADD,
        OP_SUB
    } dp_op_t;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        dp_op_t op;
        logic   res_load;
    } ctrl_t;

endpackage

FILE: rtl/asmd_ctrl.sv
// Sequencer of the signed arithmetic unit: state machine, bit counter, output valid.
// Depends on asmd_pkg.
`timescale 1ns / 1ps

module asmd_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_mode,
    output logic                 out_valid,
    input  logic                 out_ready,
    output asmd_pkg::ctrl_t      ctrl
);

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    asmd_pkg::state_t state_reg, state_next;
    asmd_pkg::mode_t  mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             can_load;
    logic             last_bit;
    logic             accept;

    // The result register may be written when empty or being drained.
    assign can_load = !out_valid_reg || out_ready;
    assign last_bit = (cnt_reg == CNT_W'(DATA_WIDTH - 1));
    assign accept   = in_valid && in_ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            asmd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == asmd_pkg::MODE_ADD || in_mode == asmd_pkg::MODE_SUB)
                        state_next = asmd_pkg::ST_ADDSUB;
                    else
                        state_next = asmd_pkg::ST_MAG_A;
                end
            end
            asmd_pkg::ST_MAG_A:  state_next = asmd_pkg::ST_MAG_B;
            asmd_pkg::ST_MAG_B:  state_next = asmd_pkg::ST_ITER;
            asmd_pkg::ST_ITER:
            begin
                if (last_bit)
                    state_next = asmd_pkg::ST_FIX;
            end
            asmd_pkg::ST_FIX,
            asmd_pkg::ST_ADDSUB:
            begin
                if (can_load)
                    state_next = asmd_pkg::ST_IDLE;
            end
            default: state_next = asmd_pkg::ST_IDLE;
        endcase
    end

    // Output logic: handshake and the datapath operation for this cycle.
    always_comb
    begin
        in_ready      = 1'b0;
        ctrl.op       = asmd_pkg::OP_HOLD;
        ctrl.res_load = 1'b0;
        unique case (state_reg)
            asmd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    ctrl.op = asmd_pkg::OP_LOAD;
            end
            asmd_pkg::ST_MAG_A: ctrl.op = asmd_pkg::OP_MAG_A;
            asmd_pkg::ST_MAG_B: ctrl.op = asmd_pkg::OP_MAG_B;
            asmd_pkg::ST_ITER:
            begin
                if (mode_reg == asmd_pkg::MODE_MUL)
                    ctrl.op = asmd_pkg::OP_MUL_STEP;
                else
                    ctrl.op = asmd_pkg::OP_DIV_STEP;
            end
            asmd_pkg::ST_FIX:
            begin
                if (can_load)
                begin
                    ctrl.res_load = 1'b1;
                    if (mode_reg == asmd_pkg::MODE_MUL)
                        ctrl.op = asmd_pkg::OP_MUL_FIX;
                    else
                        ctrl.op = asmd_pkg::OP_DIV_FIX;
                end
            end
            asmd_pkg::ST_ADDSUB:
            begin
                if (can_load)
                begin
                    ctrl.res_load = 1'b1;
                    if (mode_reg == asmd_pkg::MODE_ADD)
                        ctrl.op = asmd_pkg::OP_ADD;
                    else
                        ctrl.op = asmd_pkg::OP_SUB;
                end
            end
            default: ctrl.op = asmd_pkg::OP_HOLD;
        endcase
    end

    // Mode capture, bit counter and output valid.
    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
            mode_next = asmd_pkg::mode_t'(in_mode);

        cnt_next = cnt_reg;
        if (state_reg == asmd_pkg::ST_MAG_B)
            cnt_next = '0;
        else if (state_reg == asmd_pkg::ST_ITER)
            cnt_next = cnt_reg + CNT_W'(1);

        out_valid_next = out_valid_reg;
        if (ctrl.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asmd_pkg::ST_IDLE;
            mode_reg      <= asmd_pkg::MODE_ADD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/asmd_datapath.sv
// Datapath of the signed arithmetic unit: operand, accumulator, quotient and
// result registers around one shared add/subtract unit. Depends on asmd_pkg.
`timescale 1ns / 1ps

module asmd_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  asmd_pkg::ctrl_t       ctrl,
    input  logic [DATA_WIDTH-1:0] in_a,
    input  logic [DATA_WIDTH-1:0] in_b,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int W = DATA_WIDTH;

    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] q_reg, q_next;
    logic [W-1:0] result_reg, result_next;
    logic         neg_reg, neg_next;

    logic [W-1:0] add_x;
    logic [W-1:0] add_y;
    logic         add_inv;
    logic [W:0]   add_sum;
    logic [W-1:0] rem_shift;
    logic         take;

    // Partial remainder shifted left with the next dividend bit.
    assign rem_shift = {acc_reg[W-2:0], a_reg[W-1]};

    // Operand selection for the shared adder.
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_inv = 1'b0;
        unique case (ctrl.op)
            asmd_pkg::OP_MAG_A:
            begin
                add_y   = a_reg;
                add_inv = 1'b1;
            end
            asmd_pkg::OP_MAG_B:
            begin
                add_y   = b_reg;
                add_inv = 1'b1;
            end
            asmd_pkg::OP_MUL_STEP:
            begin
                add_x = acc_reg;
                add_y = a_reg;
            end
            asmd_pkg::OP_DIV_STEP:
            begin
                add_x   = rem_shift;
                add_y   = b_reg;
                add_inv = 1'b1;
            end
            asmd_pkg::OP_MUL_FIX:
            begin
                add_y   = acc_reg;
                add_inv = 1'b1;
            end
            asmd_pkg::OP_DIV_FIX:
            begin
                add_y   = q_reg;
                add_inv = 1'b1;
            end
            asmd_pkg::OP_ADD:
            begin
                add_x = a_reg;
                add_y = b_reg;
            end
            asmd_pkg::OP_SUB:
            begin
                add_x   = a_reg;
                add_y   = b_reg;
                add_inv = 1'b1;
            end
            default:
            begin
                add_x   = '0;
                add_y   = '0;
                add_inv = 1'b0;
            end
        endcase
    end

    // Shared adder; subtraction adds the inverted operand plus one.
    assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {W{add_inv}}} + (W+1)'(add_inv);

    // A quotient bit is set when the shifted remainder overflowed or no borrow occurred.
    assign take = acc_reg[W-1] | add_sum[W];

    // Register updates per operation.
    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        q_next      = q_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        unique case (ctrl.op)
            asmd_pkg::OP_LOAD:
            begin
                a_next   = in_a;
                b_next   = in_b;
                acc_next = '0;
                neg_next = in_a[W-1] ^ in_b[W-1];
            end
            asmd_pkg::OP_MAG_A:
            begin
                if (a_reg[W-1])
                    a_next = add_sum[W-1:0];
            end
            asmd_pkg::OP_MAG_B:
            begin
                if (b_reg[W-1])
                    b_next = add_sum[W-1:0];
            end
            asmd_pkg::OP_MUL_STEP:
            begin
                if (b_reg[0])
                    acc_next = add_sum[W-1:0];
                a_next = {a_reg[W-2:0], 1'b0};
                b_next = {1'b0, b_reg[W-1:1]};
            end
            asmd_pkg::OP_DIV_STEP:
            begin
                acc_next = take ? add_sum[W-1:0] : rem_shift;
                q_next   = {q_reg[W-2:0], take};
                a_next   = {a_reg[W-2:0], 1'b0};
            end
            asmd_pkg::OP_MUL_FIX,
            asmd_pkg::OP_DIV_FIX:
            begin
                result_next = neg_reg ? add_sum[W-1:0] : add_y;
            end
            asmd_pkg::OP_ADD,
            asmd_pkg::OP_SUB:
            begin
                result_next = add_sum[W-1:0];
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        q_reg      <= q_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

FILE: rtl/signed_add_sub_mul_div_unit.sv
// Add and subtract: after acceptance the shared adder writes the result register.
// Multiply and divide: after acceptance, magnitude steps for both operands, then one bit
// per cycle through the shared adder, then a sign-correction step that writes the result
// register. Result writes wait for a free output; each item is done before the next is taken.
// A pending result is held in the output register while the next item is taken.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops any pending result.
`timescale 1ns / 1ps

module signed_add_sub_mul_div_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: mode (2), operand_a (DATA_WIDTH), operand_b (DATA_WIDTH), zero fill.
    input  logic [((2*DATA_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: result (DATA_WIDTH), zero fill.
    output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata
);

    localparam int W         = DATA_WIDTH;
    localparam int OUT_TDATA = ((DATA_WIDTH + 7) / 8) * 8;

    asmd_pkg::ctrl_t ctrl;
    logic [W-1:0]    operand_a;
    logic [W-1:0]    operand_b;
    logic [1:0]      mode;
    logic [W-1:0]    result;

    // Unpack the input item.
    assign mode      = s_axis_tdata[1:0];
    assign operand_a = s_axis_tdata[W+1:2];
    assign operand_b = s_axis_tdata[2*W+1:W+2];

    // Sequencer.
    asmd_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (mode),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctrl      (ctrl)
    );

    // Shared-adder datapath.
    asmd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .ctrl   (ctrl),
        .in_a   (operand_a),
        .in_b   (operand_b),
        .result (result)
    );

    // Pack the result item.
    assign m_axis_tdata = OUT_TDATA'(result);

endmodule

FILE: rtl/asmd_checker.sv
// Port-level checker for the signed arithmetic unit, bound to the top level.
// Depends on signed_add_sub_mul_div_unit_macros.svh.
`timescale 1ns / 1ps
`include "signed_add_sub_mul_div_unit_macros.svh"

module asmd_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [((2*DATA_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata
);

    localparam int W = DATA_WIDTH;

    logic         in_acc;
    logic         addsub_free;
    logic [W-1:0] add_exp;
    logic [W-1:0] sub_exp;

    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign addsub_free = in_acc && !s_axis_tdata[1] && !m_axis_tvalid;
    assign add_exp     = s_axis_tdata[W+1:2] + s_axis_tdata[2*W+1:W+2];
    assign sub_exp     = s_axis_tdata[W+1:2] - s_axis_tdata[2*W+1:W+2];

    // A stalled result keeps its value.
    `ASMD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or vanished")

    // The unit works on one item at a time.
    `ASMD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !s_axis_tready,
        "input ready right after an accepted item")

    // An add or subtract accepted into an empty output shows its result once the add/subtract state has written it.
    `ASMD_ASSERT_NEXT(a_addsub_latency, clk, rst_n, addsub_free, ##1 m_axis_tvalid,
        "add or subtract result missing after two cycles")

    // That result is the wrapped sum or difference.
    `ASMD_ASSERT_NEXT(a_addsub_value, clk, rst_n, addsub_free,
        ##1 (m_axis_tdata[W-1:0] == ($past(s_axis_tdata[0], 2) ? $past(sub_exp, 2)
            : $past(add_exp, 2))), "add or subtract result wrong")

endmodule

bind signed_add_sub_mul_div_unit asmd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_asmd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/signed_add_sub_mul_div_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the signed add/subtract/multiply/divide unit.
// Depends on asmd_pkg and the unit's top level; the scoreboard predicts every result.

module signed_add_sub_mul_div_unit_tb;

    localparam int DW             = 32;
    localparam int IN_W           = ((2 * DW + 2 + 7) / 8) * 8;
    localparam int OUT_W          = ((DW + 7) / 8) * 8;
    localparam int RANDOM_ITEMS   = 900;
    localparam int WATCHDOG_LIMIT = 2000;
    // Wait at the end for longer than the slowest item takes.
    localparam int END_SETTLE     = DW + 12;

    localparam logic [DW-1:0] INT_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] INT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] ALL_ONE = {DW{1'b1}};

    // One expected result together with the item that caused it.
    typedef struct {
        asmd_pkg::mode_t mode;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
        logic [DW-1:0]   result;
    } arith_expect_t;

    // Predicts the unit's results and compares them in arrival order.
    class arith_scoreboard;
        arith_expect_t expected_q[$];
        int            errors;
        int            checked;
        int            mode_count[4];

        function new();
            errors  = 0;
            checked = 0;
            foreach (mode_count[i]) mode_count[i] = 0;
        endfunction

        // Add, subtract and multiply all reduce to wrapped two's complement
        // arithmetic. Divide works on unsigned magnitudes, so the most negative
        // value has a proper magnitude, and a zero divisor yields an all-ones magnitude.
        function logic [DW-1:0] arith_result(asmd_pkg::mode_t mode, logic [DW-1:0] a,
                                             logic [DW-1:0] b);
            logic [DW-1:0] mag_a;
            logic [DW-1:0] mag_b;
            logic [DW-1:0] quo;
            mag_a = a[DW-1] ? (~a + 1'b1) : a;
            mag_b = b[DW-1] ? (~b + 1'b1) : b;
            case (mode)
                asmd_pkg::MODE_ADD: return a + b;
                asmd_pkg::MODE_SUB: return a - b;
                asmd_pkg::MODE_MUL: return a * b;
                default:
                begin
                    quo = (mag_b == '0) ? ALL_ONE : (mag_a / mag_b);
                    return (a[DW-1] ^ b[DW-1]) ? (~quo + 1'b1) : quo;
                end
            endcase
        endfunction

        function void note_operation(asmd_pkg::mode_t mode, logic [DW-1:0] a,
                                     logic [DW-1:0] b);
            arith_expect_t exp_item;
            exp_item.mode   = mode;
            exp_item.a      = a;
            exp_item.b      = b;
            exp_item.result = arith_result(mode, a, b);
            expected_q.push_back(exp_item);
            mode_count[mode]++;
        endfunction

        function void check_result(logic [DW-1:0] got);
            arith_expect_t exp_item;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result 0x%08h, nothing was pending", $time, got);
                return;
            end
            exp_item = expected_q.pop_front();
            checked++;
            if (got !== exp_item.result)
            begin
                errors++;
                $display("%0t: %s a=%0d b=%0d: expected %0d (0x%08h), got %0d (0x%08h)",
                         $time, exp_item.mode.name(), $signed(exp_item.a), $signed(exp_item.b),
                         $signed(exp_item.result), exp_item.result, $signed(got), got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    int send_idle_pct;
    int recv_stall_pct;

    arith_scoreboard sb;

    signed_add_sub_mul_div_unit #(
        .DATA_WIDTH(DW)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Samples both handshakes at the rising edge and guards against a hang.
    initial
    begin : monitor
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            quiet_cycles++;
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_operation(asmd_pkg::mode_t'(s_axis_tdata[1:0]), s_axis_tdata[DW+1:2],
                                  s_axis_tdata[2*DW+1:DW+2]);
                quiet_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tdata[DW-1:0]);
                quiet_cycles = 0;
            end
        end
        $display("%0t: watchdog expired, %0d results still pending", $time, sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    // Offers one item after a random gap and holds it until it is taken.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_op(input asmd_pkg::mode_t mode, input logic [DW-1:0] a,
                           input logic [DW-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_W'({b, a, mode});
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // The sender goes quiet until every pending result has arrived.
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    // Operands biased toward the interesting corners, with plenty of full-range values.
    function automatic logic [DW-1:0] rand_operand();
        logic [DW-1:0] corners[7];
        corners = '{'0, DW'(1), ALL_ONE, INT_MIN, INT_MAX, INT_MIN + DW'(1),
                    INT_MAX - DW'(1)};
        case ($urandom_range(9))
            0: return corners[$urandom_range(6)];
            1: return DW'($signed($urandom_range(32)) - 16);
            2: return DW'(1) << $urandom_range(DW - 1);
            3: return DW'($urandom) >> $urandom_range(DW - 1);
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic run_random_phase(input int items, input int idle_pct, input int stall_pct);
        asmd_pkg::mode_t mode;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
        drain_results();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items)
        begin
            mode = asmd_pkg::mode_t'($urandom_range(3));
            a    = rand_operand();
            b    = rand_operand();
            // Small divisors give quotients with many set bits.
            if (mode == asmd_pkg::MODE_DIV && $urandom_range(2) == 0)
                b = DW'($signed($urandom_range(64)) - 32);
            send_op(mode, a, b);
        end
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corners: wrapping add and subtract.
        send_op(asmd_pkg::MODE_ADD, INT_MAX, DW'(1));
        send_op(asmd_pkg::MODE_ADD, INT_MIN, ALL_ONE);
        send_op(asmd_pkg::MODE_ADD, ALL_ONE, ALL_ONE);
        send_op(asmd_pkg::MODE_SUB, INT_MIN, DW'(1));
        send_op(asmd_pkg::MODE_SUB, '0, INT_MIN);
        send_op(asmd_pkg::MODE_SUB, INT_MAX, ALL_ONE);
        // Multiply: sign handling, the most negative operand and overflow.
        send_op(asmd_pkg::MODE_MUL, INT_MIN, ALL_ONE);
        send_op(asmd_pkg::MODE_MUL, INT_MAX, INT_MAX);
        send_op(asmd_pkg::MODE_MUL, ALL_ONE, ALL_ONE);
        send_op(asmd_pkg::MODE_MUL, '0, INT_MIN);
        send_op(asmd_pkg::MODE_MUL, DW'(-7), DW'(6));
        send_op(asmd_pkg::MODE_MUL, INT_MIN, INT_MIN);
        // Divide by zero with non-negative and negative dividends.
        send_op(asmd_pkg::MODE_DIV, DW'(100), '0);
        send_op(asmd_pkg::MODE_DIV, DW'(-100), '0);
        send_op(asmd_pkg::MODE_DIV, '0, '0);
        send_op(asmd_pkg::MODE_DIV, INT_MIN, '0);
        // The most negative operand, including the wrapping quotient.
        send_op(asmd_pkg::MODE_DIV, INT_MIN, ALL_ONE);
        send_op(asmd_pkg::MODE_DIV, INT_MIN, DW'(1));
        send_op(asmd_pkg::MODE_DIV, INT_MIN, INT_MIN);
        send_op(asmd_pkg::MODE_DIV, INT_MAX, INT_MIN);
        // Truncation toward zero in every sign combination.
        send_op(asmd_pkg::MODE_DIV, DW'(-7), DW'(2));
        send_op(asmd_pkg::MODE_DIV, DW'(7), DW'(-2));
        send_op(asmd_pkg::MODE_DIV, DW'(-7), DW'(-2));
        send_op(asmd_pkg::MODE_DIV, DW'(5), DW'(7));
        send_op(asmd_pkg::MODE_DIV, INT_MAX, DW'(3));

        // Random items under each idling pattern.
        run_random_phase(RANDOM_ITEMS / 4, 0, 0);
        run_random_phase(RANDOM_ITEMS / 4, 68, 0);
        run_random_phase(RANDOM_ITEMS / 4, 0, 68);
        run_random_phase(RANDOM_ITEMS / 4, 7, 7);

        // Let everything arrive, then watch for stray results.
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (END_SETTLE) @(negedge clk);

        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end

        $display("Checked %0d results: %0d add, %0d subtract, %0d multiply, %0d divide,",
                 sb.checked, sb.mode_count[asmd_pkg::MODE_ADD],
                 sb.mode_count[asmd_pkg::MODE_SUB], sb.mode_count[asmd_pkg::MODE_MUL],
                 sb.mode_count[asmd_pkg::MODE_DIV]);
        $display("over corner operands and four sender/receiver idling patterns; %0d errors.",
                 sb.errors);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
